// File: hdl/mrci_pkg.sv
// Shared types, constants and functions of the mu-law raised-cosine interpolator.
// Holds the mu-law decoder, the raised-cosine weight generator and width helpers.
// No dependencies.
package mrci_pkg;

	localparam int LEVEL_W  = 16;
	localparam int DELTA_W  = 17;
	localparam int WEIGHT_W = 16;
	localparam int PROD_W   = DELTA_W + WEIGHT_W + 1;

	localparam int MAX_SPAN_DEF           = 64;
	localparam int WEIGHT_TABLE_DEPTH_DEF = 256;
	localparam int MID_FIFO_DEPTH         = 2;
	localparam int OUT_FIFO_DEPTH         = 4;

	localparam logic signed [LEVEL_W-1:0] RESTART_LEVEL = 16'sd128;
	localparam logic [7:0] SPAN_NONE = 8'h00;
	localparam logic [7:0] CMD_SPAN  = 8'hFF;

	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIV,
		FR_PUSH
	} front_state_t;

	function automatic int span_width(int max_span);
		return $clog2(max_span + 1);
	endfunction

	function automatic int quot_width(int depth);
		return $clog2(depth + 1);
	endfunction

	// base level, delta, span, index step quotient, index step remainder
	function automatic int cmd_width(int max_span, int depth);
		return LEVEL_W + DELTA_W + 2 * span_width(max_span) + quot_width(depth);
	endfunction

	function automatic logic signed [LEVEL_W-1:0] mulaw_decode(logic [7:0] code);
		logic [7:0]  u;
		logic [15:0] t;
		u = ~code;
		t = ({9'd0, u[3:0], 3'd0} + 16'h0084) << u[6:4];
		return u[7] ? $signed(16'h0084 - t) : $signed(t - 16'h0084);
	endfunction

	// Q30 sine by a nine-term Taylor series, squared into a Q1.15 weight.
	function automatic logic [WEIGHT_W-1:0] raised_cosine_weight(longint unsigned a);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned s;
		longint unsigned sq;
		x2   = (a * a) >> 30;
		term = a;
		s    = a;
		term = ((term * x2) >> 30) / 6;   s = s - term;
		term = ((term * x2) >> 30) / 20;  s = s + term;
		term = ((term * x2) >> 30) / 42;  s = s - term;
		term = ((term * x2) >> 30) / 72;  s = s + term;
		term = ((term * x2) >> 30) / 110; s = s - term;
		term = ((term * x2) >> 30) / 156; s = s + term;
		term = ((term * x2) >> 30) / 210; s = s - term;
		term = ((term * x2) >> 30) / 272; s = s + term;
		sq   = s * s + (64'd1 << 44);
		return WEIGHT_W'(sq >> 45);
	endfunction

endpackage

// File: hdl/mulaw_raised_cosine_interpolator_unit.sv
// Top level of the mu-law raised-cosine interpolator: front end, command queue,
// back end. Uses mrci_pkg, mrci_front, mrci_fifo and mrci_back.
//
// Each pushed point carries a mu-law code and a span; the block emits span
// samples (span above MAX_SPAN saturates to it) rising from the previous level
// to the decoded one along a raised-cosine curve, and flags the final sample
// with last. Spans of zero and 0xFF are commands: they emit nothing and only
// apply restart, which sets the previous level back to 128. Rate: the back end
// emits one sample per cycle while the result queue has room; the front end
// runs each point through its restoring divider that turns depth/span into an
// index step, and overlaps this with the back end's run of the previous point
// through a two-entry command queue. A command point leaves the front end free
// for the next point. After the back end picks up a point, its samples pass the
// index step, weight table read and multiply registers to the result queue.
// No clearing pass follows reset.
module mulaw_raised_cosine_interpolator_unit #(
	parameter int MAX_SPAN           = mrci_pkg::MAX_SPAN_DEF,
	parameter int WEIGHT_TABLE_DEPTH = mrci_pkg::WEIGHT_TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         mulaw_code,
	input  logic [7:0]         span,
	input  logic               restart,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] sample,
	output logic               last
);
	import mrci_pkg::*;

	localparam int CmdW = cmd_width(MAX_SPAN, WEIGHT_TABLE_DEPTH);

	logic [CmdW-1:0] front_cmd;
	logic [CmdW-1:0] back_cmd;
	logic            mid_push;
	logic            mid_full;
	logic            mid_pop;
	logic            mid_empty;

	// Classify points, track the previous level, divide depth by span.
	mrci_front #(
		.MAX_SPAN          (MAX_SPAN),
		.WEIGHT_TABLE_DEPTH(WEIGHT_TABLE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mulaw_code(mulaw_code),
		.span      (span),
		.restart   (restart),
		.cmd_push  (mid_push),
		.cmd_full  (mid_full),
		.cmd       (front_cmd)
	);

	// Decouple the two halves so either can stall on its own.
	mrci_fifo #(
		.WIDTH(CmdW),
		.DEPTH(MID_FIFO_DEPTH)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (front_cmd),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (back_cmd),
		.empty (mid_empty),
		.count ()
	);

	// Emit one sample per cycle into the result queue while it has room.
	mrci_back #(
		.MAX_SPAN          (MAX_SPAN),
		.WEIGHT_TABLE_DEPTH(WEIGHT_TABLE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (back_cmd),
		.cmd_empty(mid_empty),
		.cmd_pop  (mid_pop),
		.sample   (sample),
		.last     (last),
		.empty    (empty),
		.pop      (pop)
	);

	a_mid_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> !mid_full)
		else $error("command transfer into a full queue");

	a_mid_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("command taken from an empty queue");

	a_point_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && span != SPAN_NONE && span != CMD_SPAN) |=> full)
		else $error("front end free right after taking a point");

	a_cmd_free: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && (span == SPAN_NONE || span == CMD_SPAN)) |=> !full)
		else $error("front end stalled after a command point");

endmodule

// File: hdl/mrci_fifo.sv
// Small register-based first-in first-out queue with occupancy count.
// Used between front and back and at the result side. No package dependency.
module mrci_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/mrci_front.sv
// Front end: accepts points, decodes mu-law, tracks the previous level and
// divides the table depth by the span for the index stepper. Uses mrci_pkg.
module mrci_front #(
	parameter int MAX_SPAN           = mrci_pkg::MAX_SPAN_DEF,
	parameter int WEIGHT_TABLE_DEPTH = mrci_pkg::WEIGHT_TABLE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] mulaw_code,
	input  logic [7:0] span,
	input  logic       restart,
	output logic       cmd_push,
	input  logic       cmd_full,
	output logic [mrci_pkg::cmd_width(MAX_SPAN, WEIGHT_TABLE_DEPTH)-1:0] cmd
);
	import mrci_pkg::*;

	localparam int SpanW = span_width(MAX_SPAN);
	localparam int QuotW = quot_width(WEIGHT_TABLE_DEPTH);
	localparam int CntW  = $clog2(QuotW);

	front_state_t state_q, state_d;

	logic signed [LEVEL_W-1:0] level_q;
	logic signed [LEVEL_W-1:0] base_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic [SpanW-1:0]          span_q;
	logic [QuotW-1:0]          quot_q;
	logic [QuotW-1:0]          dvd_q;
	logic [SpanW-1:0]          rem_q;
	logic [CntW-1:0]           cnt_q;

	logic                      accept;
	logic                      is_cmd;
	logic signed [LEVEL_W-1:0] dec;
	logic signed [LEVEL_W-1:0] base_sel;
	logic [SpanW-1:0]          span_sat;
	logic [SpanW:0]            trial;
	logic                      ge;

	assign accept   = push && !full;
	assign is_cmd   = (span == SPAN_NONE) || (span == CMD_SPAN);
	assign dec      = mulaw_decode(mulaw_code);
	assign base_sel = restart ? RESTART_LEVEL : level_q;
	assign span_sat = (span > 8'(MAX_SPAN)) ? SpanW'(MAX_SPAN) : SpanW'(span);
	assign trial    = {rem_q, dvd_q[QuotW-1]};
	assign ge       = (trial >= {1'b0, span_q});
	assign cmd      = {base_q, delta_q, span_q, quot_q, rem_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_IDLE: begin
				if (accept && !is_cmd) begin
					state_d = FR_DIV;
				end
			end
			FR_DIV: begin
				if (cnt_q == '0) begin
					state_d = FR_PUSH;
				end
			end
			FR_PUSH: begin
				if (!cmd_full) begin
					state_d = FR_IDLE;
				end
			end
			default: state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		full     = 1'b1;
		cmd_push = 1'b0;
		case (state_q)
			FR_IDLE: full = 1'b0;
			FR_DIV:  full = 1'b1;
			FR_PUSH: cmd_push = !cmd_full;
			default: full = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			level_q <= RESTART_LEVEL;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (!is_cmd) begin
					level_q <= dec;
				end else if (restart) begin
					level_q <= RESTART_LEVEL;
				end
				cnt_q <= CntW'(QuotW - 1);
			end else if (state_q == FR_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Restoring division of the table depth by the span, one quotient bit a cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q  <= base_sel;
			delta_q <= DELTA_W'(dec) - DELTA_W'(base_sel);
			span_q  <= span_sat;
			quot_q  <= '0;
			rem_q   <= '0;
			dvd_q   <= QuotW'(WEIGHT_TABLE_DEPTH);
		end else if (state_q == FR_DIV) begin
			dvd_q  <= dvd_q << 1;
			quot_q <= {quot_q[QuotW-2:0], ge};
			rem_q  <= ge ? SpanW'(trial - {1'b0, span_q}) : trial[SpanW-1:0];
		end
	end

endmodule

// File: hdl/mrci_back.sv
// Back end: steps the weight index per sample, reads the weight table,
// scales the level step, rounds and saturates. Uses mrci_pkg and mrci_fifo.
module mrci_back #(
	parameter int MAX_SPAN           = mrci_pkg::MAX_SPAN_DEF,
	parameter int WEIGHT_TABLE_DEPTH = mrci_pkg::WEIGHT_TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [mrci_pkg::cmd_width(MAX_SPAN, WEIGHT_TABLE_DEPTH)-1:0] cmd,
	input  logic               cmd_empty,
	output logic               cmd_pop,
	output logic signed [15:0] sample,
	output logic               last,
	output logic               empty,
	input  logic               pop
);
	import mrci_pkg::*;

	localparam int SpanW = span_width(MAX_SPAN);
	localparam int QuotW = quot_width(WEIGHT_TABLE_DEPTH);
	localparam int IdxW  = $clog2(WEIGHT_TABLE_DEPTH);
	localparam int OutW  = LEVEL_W + 1;
	localparam int OCntW = $clog2(OUT_FIFO_DEPTH + 1);
	localparam int RndW  = PROD_W - 15 + 1;
	localparam int SumW  = RndW + 1;

	logic [WEIGHT_W-1:0] rom [WEIGHT_TABLE_DEPTH];

	for (genvar g = 0; g < WEIGHT_TABLE_DEPTH; g++) begin : g_rom
		localparam longint unsigned Angle = (PI_Q30 * 64'(g)) / (2 * WEIGHT_TABLE_DEPTH);
		assign rom[g] = raised_cosine_weight(Angle);
	end

	logic signed [LEVEL_W-1:0] c_base;
	logic signed [DELTA_W-1:0] c_delta;
	logic [SpanW-1:0]          c_span;
	logic [QuotW-1:0]          c_qs;
	logic [SpanW-1:0]          c_rs;

	logic                      run_q;
	logic signed [LEVEL_W-1:0] base_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic [SpanW-1:0]          span_q;
	logic [QuotW-1:0]          qs_q;
	logic [SpanW-1:0]          rs_q;
	logic [SpanW-1:0]          j_q;
	logic [QuotW-1:0]          acc_q;
	logic [SpanW-1:0]          frac_q;

	logic                      vld_s1;
	logic [WEIGHT_W-1:0]       w_s1;
	logic signed [DELTA_W-1:0] delta_s1;
	logic signed [LEVEL_W-1:0] base_s1;
	logic                      last_s1;

	logic                      vld_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [LEVEL_W-1:0] base_s2;
	logic                      last_s2;

	logic                      issue;
	logic                      run_last;
	logic                      load;
	logic                      credit_ok;
	logic [SpanW:0]            fsum;
	logic                      wrap;
	logic [OCntW-1:0]          out_count;
	logic [OutW-1:0]           out_rdata;

	logic [PROD_W-1:0]         mag;
	logic [PROD_W-1:0]         mag_rnd;
	logic [RndW-1:0]           rnd;
	logic signed [SumW-1:0]    val;
	logic signed [LEVEL_W-1:0] val_sat;

	assign {c_base, c_delta, c_span, c_qs, c_rs} = cmd;

	// Hold issue while results in flight could overrun the result queue.
	assign credit_ok = ({1'b0, out_count} + (OCntW + 1)'(vld_s1) + (OCntW + 1)'(vld_s2))
		< (OCntW + 1)'(OUT_FIFO_DEPTH);
	assign issue    = run_q && credit_ok;
	assign run_last = (SpanW'(j_q + 1'b1) == span_q);
	assign load     = !cmd_empty && (!run_q || (issue && run_last));
	assign cmd_pop  = load;

	// Index step: acc + frac/span advances by depth/span each sample.
	assign fsum = {1'b0, frac_q} + {1'b0, rs_q};
	assign wrap = (fsum >= {1'b0, span_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (load) begin
				run_q <= 1'b1;
			end else if (issue && run_last) begin
				run_q <= 1'b0;
			end
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			base_q  <= c_base;
			delta_q <= c_delta;
			span_q  <= c_span;
			qs_q    <= c_qs;
			rs_q    <= c_rs;
			j_q     <= '0;
			acc_q   <= '0;
			frac_q  <= '0;
		end else if (issue) begin
			j_q    <= j_q + 1'b1;
			acc_q  <= acc_q + qs_q + QuotW'(wrap);
			frac_q <= wrap ? SpanW'(fsum - {1'b0, span_q}) : fsum[SpanW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			w_s1     <= rom[acc_q[IdxW-1:0]];
			delta_s1 <= delta_q;
			base_s1  <= base_q;
			last_s1  <= run_last;
		end
		prod_s2 <= PROD_W'(delta_s1) * $signed({1'b0, w_s1});
		base_s2 <= base_s1;
		last_s2 <= last_s1;
	end

	// Round half away from zero after the Q15 scale, then add and saturate.
	always_comb begin
		mag     = prod_s2[PROD_W-1] ? PROD_W'(-prod_s2) : PROD_W'(prod_s2);
		mag_rnd = mag + PROD_W'(16384);
		rnd     = RndW'(mag_rnd >> 15);
		val     = SumW'(base_s2) + (prod_s2[PROD_W-1] ? -$signed({1'b0, rnd})
			: $signed({1'b0, rnd}));
		if (val > SumW'(32767)) begin
			val_sat = 16'sh7FFF;
		end else if (val < -SumW'(32768)) begin
			val_sat = 16'sh8000;
		end else begin
			val_sat = LEVEL_W'(val);
		end
	end

	mrci_fifo #(
		.WIDTH(OutW),
		.DEPTH(OUT_FIFO_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (vld_s2),
		.wdata ({val_sat, last_s2}),
		.full  (),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty),
		.count (out_count)
	);

	assign sample = $signed(out_rdata[OutW-1:1]);
	assign last   = out_rdata[0];

endmodule
